[hw/rtl/pal565_pkg.sv]
package pal565_pkg;

	localparam int PALETTE_ENTRIES  = 256;
	localparam int PIXELS_PER_GROUP = 8;

	localparam int INDEX_W      = 8;
	localparam int COLOR_IN_W   = 8;
	localparam int ADDR_W       = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam int RGB_W        = 16;
	localparam int GROUP_SLOTS  = 8;
	localparam int GROUP_W      = GROUP_SLOTS * INDEX_W;
	localparam int PIX_PER_WORD = 4;
	localparam int WORD_W       = PIX_PER_WORD * RGB_W;

	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_CONVERT = 1'b1;

	typedef logic [RGB_W-1:0] rgb565_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		rgb565_t           wr_data;
		logic              rd_en;
	} lookup_ctrl_t;

	function automatic rgb565_t to_rgb565(
		input logic [COLOR_IN_W-1:0] red,
		input logic [COLOR_IN_W-1:0] green,
		input logic [COLOR_IN_W-1:0] blue
	);
		return {red[7:3], green[7:2], blue[7:3]};
	endfunction

	function automatic logic index_in_range(input logic [INDEX_W-1:0] idx);
		return {1'b0, idx} < (INDEX_W + 1)'(PALETTE_ENTRIES);
	endfunction

endpackage

[hw/rtl/palette_to_rgb565_converter_top.sv]
// Channel | Handshake            | Payload
// --------+----------------------+----------------------------------------------
// in      | in_valid / in_ready  | operation, entry_index, red_in, green_in,
//         |                      | blue_in, pixel_group, frame_end_in
// out     | out_valid / out_ready| low_pixels, high_pixels, frame_end_out
//
// One item per cycle unless the out channel stalls; a convert item's result passes through
// the input register and then the registered read of the eight palette banks.
// Palette writes produce no result and retire from the input register even when out stalls.
// An out stall holds the result; a convert item waits in the input register and in_ready drops.
// Reset clears valid flags only; the palette is undefined until written, no clearing pass.
module palette_to_rgb565_converter_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                operation,
	input  logic [pal565_pkg::INDEX_W-1:0]      entry_index,
	input  logic [pal565_pkg::COLOR_IN_W-1:0]   red_in,
	input  logic [pal565_pkg::COLOR_IN_W-1:0]   green_in,
	input  logic [pal565_pkg::COLOR_IN_W-1:0]   blue_in,
	input  logic [pal565_pkg::GROUP_W-1:0]      pixel_group,
	input  logic                                frame_end_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [pal565_pkg::WORD_W-1:0]       low_pixels,
	output logic [pal565_pkg::WORD_W-1:0]       high_pixels,
	output logic                                frame_end_out
);
	import pal565_pkg::*;

	logic               valid_s1;
	logic               op_s1;
	logic               wr_ok_s1;
	logic [ADDR_W-1:0]  wr_addr_s1;
	rgb565_t            wr_data_s1;
	logic [GROUP_W-1:0] group_s1;
	logic               frame_end_s1;
	logic               frame_end_s2;
	logic               out_valid_q;

	logic         adv2;
	logic         conv_s1;
	logic         drain_s1;
	lookup_ctrl_t ctrl;

	assign adv2     = !out_valid_q || out_ready;
	assign conv_s1  = valid_s1 && (op_s1 == OP_CONVERT);
	assign drain_s1 = valid_s1 && ((op_s1 == OP_WRITE) || adv2);
	assign in_ready = !valid_s1 || drain_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1        <= operation;
			wr_ok_s1     <= index_in_range(entry_index);
			wr_addr_s1   <= entry_index[ADDR_W-1:0];
			wr_data_s1   <= to_rgb565(red_in, green_in, blue_in);
			group_s1     <= pixel_group;
			frame_end_s1 <= frame_end_in;
		end
	end

	always_comb begin
		ctrl.wr_en   = valid_s1 && (op_s1 == OP_WRITE) && wr_ok_s1;
		ctrl.wr_addr = wr_addr_s1;
		ctrl.wr_data = wr_data_s1;
		ctrl.rd_en   = conv_s1 && adv2;
	end

	pal565_lookup u_lookup (
		.clk         (clk),
		.ctrl        (ctrl),
		.pixel_group (group_s1),
		.low_pixels  (low_pixels),
		.high_pixels (high_pixels)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv2) begin
			out_valid_q <= conv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			frame_end_s2 <= frame_end_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_end_out = frame_end_s2;

	a_write_never_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (op_s1 == OP_WRITE)) |-> in_ready)
		else $error("palette write held in input register");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (conv_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a blocked result");

	a_convert_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.rd_en |=> out_valid)
		else $error("convert item lost between stages");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.wr_en && ctrl.rd_en))
		else $error("palette read and write in the same cycle");

endmodule

[hw/rtl/pal565_palette_bank.sv]
module pal565_palette_bank (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [pal565_pkg::ADDR_W-1:0] wr_addr,
	input  pal565_pkg::rgb565_t       wr_data,
	input  logic                      rd_en,
	input  logic [pal565_pkg::ADDR_W-1:0] rd_addr,
	output pal565_pkg::rgb565_t       rd_data
);
	import pal565_pkg::*;

	rgb565_t mem [PALETTE_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hw/rtl/pal565_lookup.sv]
module pal565_lookup (
	input  logic                           clk,
	input  pal565_pkg::lookup_ctrl_t       ctrl,
	input  logic [pal565_pkg::GROUP_W-1:0] pixel_group,
	output logic [pal565_pkg::WORD_W-1:0]  low_pixels,
	output logic [pal565_pkg::WORD_W-1:0]  high_pixels
);
	import pal565_pkg::*;

	rgb565_t pix [GROUP_SLOTS];

	for (genvar k = 0; k < GROUP_SLOTS; k++) begin : g_slot
		if (k < PIXELS_PER_GROUP) begin : g_bank
			logic [INDEX_W-1:0] idx;
			rgb565_t            rd_s2;
			logic               zero_s2;

			assign idx = pixel_group[k*INDEX_W +: INDEX_W];

			// one copy of the palette per slot, all written together
			pal565_palette_bank u_bank (
				.clk     (clk),
				.wr_en   (ctrl.wr_en),
				.wr_addr (ctrl.wr_addr),
				.wr_data (ctrl.wr_data),
				.rd_en   (ctrl.rd_en),
				.rd_addr (idx[ADDR_W-1:0]),
				.rd_data (rd_s2)
			);

			always_ff @(posedge clk) begin
				if (ctrl.rd_en) begin
					zero_s2 <= !index_in_range(idx);
				end
			end

			assign pix[k] = zero_s2 ? '0 : rd_s2;
		end else begin : g_unused
			assign pix[k] = '0;
		end
	end

	always_comb begin
		for (int k = 0; k < PIX_PER_WORD; k++) begin
			low_pixels[k*RGB_W +: RGB_W]  = pix[k];
			high_pixels[k*RGB_W +: RGB_W] = pix[k+PIX_PER_WORD];
		end
	end

endmodule
